// File: src/hpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform core.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int DOT_LAT   = 4;
    localparam int DIV_STEPS = 33;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int TOTAL_LAT = 1 + DOT_LAT + DIV_LAT;

    localparam logic OP_LINEAR = 1'b1;

    localparam logic [NUM_REGS-1:0][63:0] REG_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef logic [3:0][31:0] t_row;
    typedef t_row [3:0]       t_mat;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    typedef struct packed {
        logic vld;
        logic lin;
        logic wz;
    } t_ctl;

endpackage

// File: src/hpt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_cfg
// Matrix register file: eight 64-bit registers, two Q16.16 entries each.
// ----------------------------------------------------------------------------
module hpt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [63:0]                   i_wdata,
    output hpt_pkg::t_mat                 o_mat
);

    logic [hpt_pkg::NUM_REGS-1:0][63:0] r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= hpt_pkg::REG_RESET;
        end else if (i_we && !i_idx[hpt_pkg::CFG_IDX_W-1]) begin
            r_regs[i_idx[hpt_pkg::CFG_IDX_W-2:0]] <= i_wdata;
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        assign o_mat[r] = {r_regs[2*r+1], r_regs[2*r]};
    end

endmodule

// File: src/hpt_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_dot
// One matrix row times the point: multiply, two adder levels, sign/magnitude.
// ----------------------------------------------------------------------------
module hpt_dot (
    input  logic               i_clk,
    input  hpt_pkg::t_row      i_row,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic               i_trans,
    output hpt_pkg::t_sm       o_sum
);

    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [64:0] r_s01, r_s23;
    logic signed [65:0] r_s;
    logic [65:0]        n_abs;

    always_comb begin
        n_abs = r_s[65] ? (66'd0 - r_s) : r_s;
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= $signed(i_row[0]) * i_x;
        r_p1  <= $signed(i_row[1]) * i_y;
        r_p2  <= $signed(i_row[2]) * i_z;
        r_p3  <= i_trans ? {{16{i_row[3][31]}}, i_row[3], 16'd0} : 64'd0;
        r_s01 <= {r_p0[63], r_p0} + {r_p1[63], r_p1};
        r_s23 <= {r_p2[63], r_p2} + {r_p3[63], r_p3};
        r_s   <= {r_s01[64], r_s01} + {r_s23[64], r_s23};
        o_sum <= '{neg: r_s[65], mag: n_abs[63:0]};
    end

endmodule

// File: src/hpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divide of one coordinate by w (bypassed for linear mode or
// zero w), one quotient bit per stage, then truncation and saturation to signed Q16.16.
// ----------------------------------------------------------------------------
module hpt_div (
    input  logic         i_clk,
    input  hpt_pkg::t_sm i_num,
    input  hpt_pkg::t_sm i_den,
    input  logic         i_lin,
    output logic [31:0]  o_val,
    output logic         o_sat
);

    localparam int NS = hpt_pkg::DIV_STEPS;

    typedef struct packed {
        logic [63:0]   rem;
        logic [NS-1:0] q;
        logic [63:0]   num;
        logic [63:0]   den;
        logic          neg;
        logic          byp;
        logic          ovf;
    } t_dst;

    t_dst        r_st [0:NS];
    t_dst        n_st [1:NS];
    logic [48:0] n_m;
    logic [31:0] n_val;
    logic        n_sat;

    always_ff @(posedge i_clk) begin
        r_st[0].rem <= {17'd0, i_num.mag[63:17]};
        r_st[0].q   <= '0;
        r_st[0].num <= i_num.mag;
        r_st[0].den <= i_den.mag;
        r_st[0].byp <= i_lin || (i_den.mag == 64'd0);
        r_st[0].neg <= (i_lin || (i_den.mag == 64'd0)) ? i_num.neg
                                                         : (i_num.neg ^ i_den.neg);
        r_st[0].ovf <= {17'd0, i_num.mag} >= {i_den.mag, 17'd0};
    end

    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int B = NS - 1 - j;
        logic        xb;
        logic [64:0] t;

        if (B >= 16) begin : g_bit
            assign xb = r_st[j].num[B-16];
        end else begin : g_zero
            assign xb = 1'b0;
        end

        always_comb begin
            t       = {r_st[j].rem, xb};
            n_st[j+1] = r_st[j];
            n_st[j+1].rem = t[63:0];
            if (t >= {1'b0, r_st[j].den}) begin
                n_st[j+1].rem  = 64'(t - {1'b0, r_st[j].den});
                n_st[j+1].q[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[j+1] <= n_st[j+1];
        end
    end

    always_comb begin
        priority if (r_st[NS].byp) begin
            n_m = {1'b0, r_st[NS].num[63:16]};
        end else if (r_st[NS].ovf) begin
            n_m = 49'h1_0000_0000_0000;
        end else begin
            n_m = {16'd0, r_st[NS].q};
        end
        n_sat = 1'b0;
        if (r_st[NS].neg) begin
            if (n_m > 49'h0_0000_8000_0000) begin
                n_sat = 1'b1;
                n_val = 32'h8000_0000;
            end else begin
                n_val = 32'(49'd0 - n_m);
            end
        end else begin
            if (n_m > 49'h0_0000_7FFF_FFFF) begin
                n_sat = 1'b1;
                n_val = 32'h7FFF_FFFF;
            end else begin
                n_val = n_m[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_val <= n_val;
        o_sat <= n_sat;
    end

endmodule

// File: src/homogeneous_point_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// Transforms Q16.16 points by a configurable 4x4 matrix, with w divide unless linear.
// ----------------------------------------------------------------------------
// One request is taken every cycle; o_busy is always low. Each result is shown
// on o_valid for one cycle, in request order, after one input register, four
// stages of multiply and row sum, and a 35-stage divide section: an entry
// register, one quotient bit per stage over 33 bits, and an output register.
// Results must be taken when shown.
// Write the matrix only while no request is in flight.
module homogeneous_point_transform_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic signed [31:0]            i_point_x,
    input  logic signed [31:0]            i_point_y,
    input  logic signed [31:0]            i_point_z,
    output logic                          o_valid,
    output logic signed [31:0]            o_out_x,
    output logic signed [31:0]            o_out_y,
    output logic signed [31:0]            o_out_z,
    output logic                          o_w_was_zero,
    output logic                          o_saturated,
    input  logic                          i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_wdata
);

    hpt_pkg::t_mat      w_mat;
    hpt_pkg::t_sm       w_sum [0:3];
    hpt_pkg::t_ctl      r_c1 [0:hpt_pkg::DOT_LAT-1];
    hpt_pkg::t_ctl      r_c2 [0:hpt_pkg::DIV_LAT-1];
    logic               r_vld;
    logic               r_lin;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [31:0]        w_val [0:2];
    logic [2:0]         w_sat;

    assign o_busy = 1'b0;

    hpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_mat   (w_mat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start && !o_busy;
        end
        r_lin <= (i_operation == hpt_pkg::OP_LINEAR);
        r_px  <= i_point_x;
        r_py  <= i_point_y;
        r_pz  <= i_point_z;
    end

    for (genvar r = 0; r < 4; r++) begin : g_dot
        hpt_dot u_dot (
            .i_clk   (i_clk),
            .i_row   (w_mat[r]),
            .i_x     (r_px),
            .i_y     (r_py),
            .i_z     (r_pz),
            .i_trans (!r_lin || (r == 3)),
            .o_sum   (w_sum[r])
        );
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        hpt_div u_div (
            .i_clk (i_clk),
            .i_num (w_sum[k]),
            .i_den (w_sum[3]),
            .i_lin (r_c1[hpt_pkg::DOT_LAT-1].lin),
            .o_val (w_val[k]),
            .o_sat (w_sat[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::DOT_LAT; i++) begin
                r_c1[i] <= '0;
            end
            for (int i = 0; i < hpt_pkg::DIV_LAT; i++) begin
                r_c2[i] <= '0;
            end
        end else begin
            r_c1[0] <= '{vld: r_vld, lin: r_lin, wz: 1'b0};
            for (int i = 1; i < hpt_pkg::DOT_LAT; i++) begin
                r_c1[i] <= r_c1[i-1];
            end
            r_c2[0] <= '{vld: r_c1[hpt_pkg::DOT_LAT-1].vld,
                         lin: r_c1[hpt_pkg::DOT_LAT-1].lin,
                         wz:  !r_c1[hpt_pkg::DOT_LAT-1].lin
                              && (w_sum[3].mag == 64'd0)};
            for (int i = 1; i < hpt_pkg::DIV_LAT; i++) begin
                r_c2[i] <= r_c2[i-1];
            end
        end
    end

    assign o_valid      = r_c2[hpt_pkg::DIV_LAT-1].vld;
    assign o_w_was_zero = r_c2[hpt_pkg::DIV_LAT-1].vld && r_c2[hpt_pkg::DIV_LAT-1].wz;
    assign o_saturated  = r_c2[hpt_pkg::DIV_LAT-1].vld && (|w_sat);
    assign o_out_x      = w_val[0];
    assign o_out_y      = w_val[1];
    assign o_out_z      = w_val[2];

`ifndef SYNTH
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, hpt_pkg::TOTAL_LAT))
        else $error("result without matching request");

    a_wzero_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_w_was_zero |-> !$past(i_operation, hpt_pkg::TOTAL_LAT))
        else $error("zero w flagged for linear request");

    a_sat_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_out_x == 32'sh7FFF_FFFF || o_out_x == 32'sh8000_0000 ||
                         o_out_y == 32'sh7FFF_FFFF || o_out_y == 32'sh8000_0000 ||
                         o_out_z == 32'sh7FFF_FFFF || o_out_z == 32'sh8000_0000))
        else $error("saturation flag without clamped coordinate");
`endif

endmodule
